FILE: design/ears_pkg.sv
// ----------------------------------------------------------------------------
// ears_pkg
// Shared types and constants for the energy-aware relay selector.
// ----------------------------------------------------------------------------
`default_nettype none
package ears_pkg;

    localparam int MulW      = 32;
    localparam int MulCntW   = 6;
    localparam int DivNumW   = 51;
    localparam int DivDenW   = 35;
    localparam int DivCntW   = 6;
    localparam int SqrtRadW  = 34;
    localparam int SqrtRootW = 17;
    localparam int SqrtCntW  = 5;

    localparam logic [1:0] CMD_INFO    = 2'd0;
    localparam logic [1:0] CMD_REPORT  = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [1:0] CMD_PAYLOAD = 2'd3;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_BS     = 2'd1;
    localparam logic [1:0] EV_RELAY  = 2'd2;
    localparam logic [1:0] EV_BACKUP = 2'd3;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_FORWARD = 3'd1;
    localparam logic [2:0] ACT_SW_FWD  = 3'd2;
    localparam logic [2:0] ACT_DROP    = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;

    localparam logic [2:0] REG_OWN_X    = 3'd0;
    localparam logic [2:0] REG_OWN_Y    = 3'd1;
    localparam logic [2:0] REG_OWN_DBS  = 3'd2;
    localparam logic [2:0] REG_CRIT     = 3'd3;
    localparam logic [2:0] REG_SWITCH   = 3'd4;
    localparam logic [2:0] REG_IS_BS    = 3'd5;

    typedef struct packed {
        logic [15:0] addr;
        logic [23:0] energy;
        logic [16:0] dist_bs;
        logic [16:0] hop_dist;
    } node_t;

    typedef struct packed {
        node_t relay;
        node_t backup;
        logic  sw;
        logic  req;
    } chk_t;

endpackage
`default_nettype wire

FILE: design/ears_mul.sv
// ----------------------------------------------------------------------------
// ears_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ears_mul import ears_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [MulW-1:0]   a,
    input  wire logic [MulW-1:0]   b,
    output logic                   done,
    output logic [2*MulW-1:0]      p
);
    logic [MulCntW-1:0] cnt_reg;
    logic               done_reg;
    logic [MulW-1:0]    a_reg;
    logic [2*MulW-1:0]  prod_reg;
    logic [MulW:0]      sum;

    assign sum = {1'b0, prod_reg[2*MulW-1:MulW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= MulCntW'(MulW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MulCntW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{MulW{1'b0}}, b};
        end else if (cnt_reg != '0) begin
            prod_reg <= {sum, prod_reg[MulW-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = prod_reg;
endmodule
`default_nettype wire

FILE: design/ears_div.sv
// ----------------------------------------------------------------------------
// ears_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module ears_div import ears_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DivNumW-1:0] num,
    input  wire logic [DivDenW-1:0] den,
    output logic                    done,
    output logic [31:0]             quo
);
    logic [DivCntW-1:0] cnt_reg;
    logic               done_reg;
    logic [DivDenW-1:0] den_reg;
    logic [DivDenW-1:0] rem_reg;
    logic [DivNumW-1:0] q_reg;
    logic [DivDenW:0]   trial;
    logic [DivDenW:0]   diff;
    logic               ge;

    assign trial = {rem_reg, q_reg[DivNumW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= DivCntW'(DivNumW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DivCntW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= num;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
            q_reg   <= {q_reg[DivNumW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = (|q_reg[DivNumW-1:32]) ? 32'hFFFF_FFFF : q_reg[31:0];
endmodule
`default_nettype wire

FILE: design/ears_isqrt.sv
// ----------------------------------------------------------------------------
// ears_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ears_isqrt import ears_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [SqrtRadW-1:0]  rad,
    output logic                      done,
    output logic [SqrtRootW-1:0]      root
);
    logic [SqrtCntW-1:0]  cnt_reg;
    logic                 done_reg;
    logic [SqrtRadW-1:0]  rad_reg;
    logic [SqrtRootW+1:0] rem_reg;
    logic [SqrtRootW-1:0] root_reg;
    logic [SqrtRootW+2:0] trial;
    logic [SqrtRootW+2:0] sub;
    logic [SqrtRootW+2:0] diff;
    logic                 ge;

    assign trial = {rem_reg[SqrtRootW:0], rad_reg[SqrtRadW-1:SqrtRadW-2]};
    assign sub   = {1'b0, root_reg, 2'b01};
    assign diff  = trial - sub;
    assign ge    = trial >= sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= SqrtCntW'(SqrtRootW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SqrtCntW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[SqrtRadW-3:0], 2'b00};
            rem_reg  <= ge ? diff[SqrtRootW+1:0] : trial[SqrtRootW+1:0];
            root_reg <= {root_reg[SqrtRootW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

FILE: design/ears_score.sv
// ----------------------------------------------------------------------------
// ears_score
// Candidate score in Q16.16: energy/dist_bs times (dc^2+db^2-dr^2)/(2*dr*db).
// ----------------------------------------------------------------------------
`default_nettype none
module ears_score import ears_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [23:0] e,
    input  wire logic [16:0] dc,
    input  wire logic [16:0] db,
    input  wire logic [16:0] dr,
    output logic             done,
    output logic [31:0]      score
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_M4   = 4'd4;
    localparam logic [3:0] S_D1   = 4'd5;
    localparam logic [3:0] S_D2   = 4'd6;
    localparam logic [3:0] S_M5   = 4'd7;

    logic [3:0]          state_reg;
    logic                kick_reg;
    logic                done_reg;
    logic [31:0]         score_reg;
    logic [34:0]         pos_reg;
    logic [33:0]         neg_reg;
    logic [34:0]         den_reg;
    logic [31:0]         c_reg;
    logic [31:0]         q_reg;
    logic [MulW-1:0]     mul_a;
    logic [MulW-1:0]     mul_b;
    logic                mul_done;
    logic [2*MulW-1:0]   mul_p;
    logic                div_start;
    logic [DivNumW-1:0]  div_num;
    logic [DivDenW-1:0]  div_den;
    logic                div_done;
    logic [31:0]         div_q;
    logic [34:0]         diff;

    assign diff = pos_reg - {1'b0, neg_reg};

    always_comb begin
        case (state_reg)
            S_M1:    begin mul_a = {15'd0, dc}; mul_b = {15'd0, dc}; end
            S_M2:    begin mul_a = {15'd0, db}; mul_b = {15'd0, db}; end
            S_M3:    begin mul_a = {15'd0, dr}; mul_b = {15'd0, dr}; end
            S_M4:    begin mul_a = {15'd0, dr}; mul_b = {15'd0, db}; end
            S_M5:    begin mul_a = q_reg;       mul_b = c_reg;       end
            default: begin mul_a = '0;          mul_b = '0;          end
        endcase
        if (state_reg == S_D1) begin
            div_num = {diff, 16'd0};
            div_den = den_reg;
        end else begin
            div_num = {11'd0, e, 16'd0};
            div_den = {18'd0, dr};
        end
    end

    assign div_start = kick_reg && (state_reg == S_D1 || state_reg == S_D2);

    ears_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kick_reg && state_reg != S_D1 && state_reg != S_D2 && state_reg != S_IDLE),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    ears_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kick_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            kick_reg <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        if (db == '0 || dr == '0) begin
                            done_reg <= 1'b1;
                        end else begin
                            state_reg <= S_M1;
                            kick_reg  <= 1'b1;
                        end
                    end
                end
                S_M1: if (mul_done) begin state_reg <= S_M2; kick_reg <= 1'b1; end
                S_M2: if (mul_done) begin state_reg <= S_M3; kick_reg <= 1'b1; end
                S_M3: begin
                    if (mul_done) begin
                        // non-positive cosine scores zero
                        if (pos_reg <= {1'b0, mul_p[33:0]}) begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                        end else begin
                            state_reg <= S_M4;
                            kick_reg  <= 1'b1;
                        end
                    end
                end
                S_M4: if (mul_done) begin state_reg <= S_D1; kick_reg <= 1'b1; end
                S_D1: if (div_done) begin state_reg <= S_D2; kick_reg <= 1'b1; end
                S_D2: if (div_done) begin state_reg <= S_M5; kick_reg <= 1'b1; end
                S_M5: begin
                    if (mul_done) begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            score_reg <= '0;
        end
        if (mul_done) begin
            case (state_reg)
                S_M1: pos_reg <= {1'b0, mul_p[33:0]};
                S_M2: pos_reg <= pos_reg + {1'b0, mul_p[33:0]};
                S_M3: neg_reg <= mul_p[33:0];
                S_M4: den_reg <= {mul_p[33:0], 1'b0};
                S_M5: score_reg <= (|mul_p[63:48]) ? 32'hFFFF_FFFF : mul_p[47:16];
                default: ;
            endcase
        end
        if (div_done) begin
            if (state_reg == S_D1) begin
                c_reg <= div_q;
            end else begin
                q_reg <= div_q;
            end
        end
    end

    assign done  = done_reg;
    assign score = score_reg;
endmodule
`default_nettype wire

FILE: design/energy_aware_relay_selector.sv
// Flow: a beat that needs no scoring goes from ST_IDLE to ST_DECIDE, which
// registers its result beat once the output is free. A relay-info beat that
// scores candidates passes ST_SQX, ST_SQY, ST_ROOT, ST_SCC, ST_SCR and ST_SCB:
// two squares, a root and three scores (up to five 32-step multiplies and two
// 51-step divides each). One beat at a time: s_tready is high only in ST_IDLE.
// Reset: synchronous active-low aresetn clears the control state, configuration and all node state.
// ----------------------------------------------------------------------------
// energy_aware_relay_selector
// Tracks base station, relay and backup nodes and routes relayed payloads.
// ----------------------------------------------------------------------------
`default_nettype none
module energy_aware_relay_selector import ears_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // src_addr, energy, pos_x, pos_y, cand_dist_bs, zero pad
    input  wire logic [95:0] s_tdata,
    // command, sender_is_bs
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // next_hop, relay_addr_out, backup_addr_out, selection_event, switched,
    // request_relay, payload_action, send_energy_ack
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQX    = 3'd1;
    localparam logic [2:0] ST_SQY    = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_SCC    = 3'd4;
    localparam logic [2:0] ST_SCR    = 3'd5;
    localparam logic [2:0] ST_SCB    = 3'd6;
    localparam logic [2:0] ST_DECIDE = 3'd7;

    logic [2:0]  state_reg;
    logic        kick_reg;
    logic [15:0] own_x_reg, own_y_reg;
    logic [16:0] own_dbs_reg;
    logic [23:0] crit_reg, swe_reg;
    logic        is_bs_reg;
    logic [15:0] bs_addr_reg;
    node_t       relay_reg, backup_reg;
    logic [1:0]  cmd_reg;
    logic        from_bs_reg;
    logic [15:0] src_reg;
    logic [23:0] en_reg;
    logic [16:0] cdbs_reg;
    logic [15:0] dx_reg, dy_reg;
    logic [31:0] sqx_reg;
    logic [32:0] rad_reg;
    logic [16:0] dc_reg;
    logic [31:0] sc_c_reg, sc_r_reg, sc_b_reg;
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic [15:0] in_src, in_px, in_py;
    logic        mul_done, sqrt_done, sc_done;
    logic [63:0] mul_p;
    logic [16:0] sqrt_root;
    logic [31:0] sc_val;
    logic [23:0] sc_e;
    logic [16:0] sc_dc, sc_dr;
    logic        out_free;
    logic [15:0] bs_nx;
    node_t       rl_nx, bk_nx, cand;
    logic [1:0]  ev_nx;
    logic        sw_nx, req_nx, ack_nx;
    logic [2:0]  act_nx;
    chk_t        chk;

    function automatic chk_t energy_check(node_t r, node_t b, logic bs_known,
                                          logic [23:0] crit, logic [23:0] swe);
        chk_t c;
        c.relay  = r;
        c.backup = b;
        c.sw     = 1'b0;
        c.req    = 1'b0;
        if (!bs_known) begin
            if (r.energy < crit || r.addr == '0) begin
                if (b.energy < crit || b.addr == '0) begin
                    c.req = 1'b1;
                end else begin
                    c.relay = b; c.backup = r; c.sw = 1'b1;
                end
            end else if (b.addr != '0 && b.energy > r.energy &&
                         (b.energy - r.energy) > swe) begin
                c.relay = b; c.backup = r; c.sw = 1'b1;
            end
        end
        return c;
    endfunction

    assign in_src    = s_tdata[15:0];
    assign in_px     = s_tdata[55:40];
    assign in_py     = s_tdata[71:56];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    ears_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kick_reg && (state_reg == ST_SQX || state_reg == ST_SQY)),
        .a       ((state_reg == ST_SQX) ? {16'd0, dx_reg} : {16'd0, dy_reg}),
        .b       ((state_reg == ST_SQX) ? {16'd0, dx_reg} : {16'd0, dy_reg}),
        .done    (mul_done),
        .p       (mul_p)
    );

    ears_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kick_reg && state_reg == ST_ROOT),
        .rad     ({1'b0, rad_reg}),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_comb begin
        case (state_reg)
            ST_SCR: begin
                sc_e = relay_reg.energy; sc_dc = relay_reg.hop_dist;
                sc_dr = relay_reg.dist_bs;
            end
            ST_SCB: begin
                sc_e = backup_reg.energy; sc_dc = backup_reg.hop_dist;
                sc_dr = backup_reg.dist_bs;
            end
            default: begin
                sc_e = en_reg; sc_dc = dc_reg; sc_dr = cdbs_reg;
            end
        endcase
    end

    ears_score u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kick_reg && (state_reg == ST_SCC || state_reg == ST_SCR ||
                               state_reg == ST_SCB)),
        .e       (sc_e),
        .dc      (sc_dc),
        .db      (own_dbs_reg),
        .dr      (sc_dr),
        .done    (sc_done),
        .score   (sc_val)
    );

    // outcome of the beat, applied in ST_DECIDE
    always_comb begin
        bs_nx  = bs_addr_reg;
        rl_nx  = relay_reg;
        bk_nx  = backup_reg;
        ev_nx  = EV_NONE;
        sw_nx  = 1'b0;
        req_nx = 1'b0;
        act_nx = ACT_NONE;
        ack_nx = 1'b0;
        cand   = '{addr: src_reg, energy: en_reg, dist_bs: cdbs_reg, hop_dist: dc_reg};
        chk    = '0;
        case (cmd_reg)
            CMD_INFO: begin
                if (from_bs_reg) begin
                    bs_nx = src_reg;
                    ev_nx = EV_BS;
                end else if (bs_addr_reg == '0) begin
                    if (relay_reg.addr == '0) begin
                        rl_nx = cand; ev_nx = EV_RELAY;
                    end else if (sc_c_reg > sc_r_reg) begin
                        bk_nx = relay_reg; rl_nx = cand; ev_nx = EV_RELAY;
                    end else if (backup_reg.addr == '0 || sc_c_reg > sc_b_reg) begin
                        bk_nx = cand; ev_nx = EV_BACKUP;
                    end
                end
            end
            CMD_REPORT: begin
                if (bs_addr_reg == '0) begin
                    if (src_reg == rl_nx.addr) begin
                        rl_nx.energy = en_reg;
                    end else if (src_reg == bk_nx.addr) begin
                        bk_nx.energy = en_reg;
                    end
                    chk    = energy_check(rl_nx, bk_nx, 1'b0, crit_reg, swe_reg);
                    rl_nx  = chk.relay;
                    bk_nx  = chk.backup;
                    sw_nx  = chk.sw;
                    req_nx = chk.req;
                end
            end
            CMD_TIMEOUT: begin
                rl_nx.addr = '0;
                chk    = energy_check(rl_nx, bk_nx, bs_addr_reg != '0, crit_reg, swe_reg);
                rl_nx  = chk.relay;
                bk_nx  = chk.backup;
                sw_nx  = chk.sw;
                req_nx = chk.req;
            end
            default: begin
                if (is_bs_reg) begin
                    act_nx = ACT_DELIVER; ack_nx = 1'b1;
                end else if (bs_addr_reg != '0 ||
                             (relay_reg.addr != '0 && relay_reg.addr != src_reg)) begin
                    act_nx = ACT_FORWARD; ack_nx = 1'b1;
                end else if (backup_reg.addr != '0 && backup_reg.addr != src_reg) begin
                    rl_nx = backup_reg;
                    bk_nx = relay_reg;
                    bk_nx.addr = '0;
                    sw_nx = 1'b1; act_nx = ACT_SW_FWD; ack_nx = 1'b1;
                end else begin
                    act_nx = ACT_DROP;
                    if (src_reg == relay_reg.addr) begin
                        rl_nx.addr = '0;
                        chk    = energy_check(rl_nx, bk_nx, 1'b0, crit_reg, swe_reg);
                        rl_nx  = chk.relay;
                        bk_nx  = chk.backup;
                        sw_nx  = chk.sw;
                        req_nx = chk.req;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kick_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            own_x_reg   <= '0;
            own_y_reg   <= '0;
            own_dbs_reg <= '0;
            crit_reg    <= '0;
            swe_reg     <= '0;
            is_bs_reg   <= 1'b0;
            bs_addr_reg <= '0;
            relay_reg   <= '0;
            backup_reg  <= '0;
        end else begin
            kick_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_OWN_X:   own_x_reg   <= cfg_data[15:0];
                    REG_OWN_Y:   own_y_reg   <= cfg_data[15:0];
                    REG_OWN_DBS: own_dbs_reg <= cfg_data[16:0];
                    REG_CRIT:    crit_reg    <= cfg_data;
                    REG_SWITCH:  swe_reg     <= cfg_data;
                    REG_IS_BS:   is_bs_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[1:0] == CMD_INFO && !s_tuser[2] && bs_addr_reg == '0) begin
                            state_reg <= ST_SQX;
                            kick_reg  <= 1'b1;
                        end else begin
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_SQX:  if (mul_done)  begin state_reg <= ST_SQY;  kick_reg <= 1'b1; end
                ST_SQY:  if (mul_done)  begin state_reg <= ST_ROOT; kick_reg <= 1'b1; end
                ST_ROOT: if (sqrt_done) begin state_reg <= ST_SCC;  kick_reg <= 1'b1; end
                ST_SCC:  if (sc_done)   begin state_reg <= ST_SCR;  kick_reg <= 1'b1; end
                ST_SCR:  if (sc_done)   begin state_reg <= ST_SCB;  kick_reg <= 1'b1; end
                ST_SCB:  if (sc_done)   begin state_reg <= ST_DECIDE; end
                ST_DECIDE: begin
                    if (out_free) begin
                        bs_addr_reg <= bs_nx;
                        relay_reg   <= rl_nx;
                        backup_reg  <= bk_nx;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            cmd_reg     <= s_tuser[1:0];
            from_bs_reg <= s_tuser[2];
            src_reg     <= in_src;
            en_reg      <= s_tdata[39:16];
            cdbs_reg    <= s_tdata[88:72];
            dx_reg      <= (own_x_reg > in_px) ? own_x_reg - in_px : in_px - own_x_reg;
            dy_reg      <= (own_y_reg > in_py) ? own_y_reg - in_py : in_py - own_y_reg;
        end
        if (mul_done && state_reg == ST_SQX) begin
            sqx_reg <= mul_p[31:0];
        end
        if (mul_done && state_reg == ST_SQY) begin
            rad_reg <= {1'b0, sqx_reg} + {1'b0, mul_p[31:0]};
        end
        if (sqrt_done) begin
            dc_reg <= sqrt_root;
        end
        if (sc_done) begin
            case (state_reg)
                ST_SCC:  sc_c_reg <= sc_val;
                ST_SCR:  sc_r_reg <= sc_val;
                ST_SCB:  sc_b_reg <= sc_val;
                default: ;
            endcase
        end
        if (state_reg == ST_DECIDE && out_free) begin
            m_data_reg <= {ack_nx, act_nx, req_nx, sw_nx, ev_nx, bk_nx.addr, rl_nx.addr,
                           (bs_nx != '0) ? bs_nx : rl_nx.addr};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire
